### design/gtg_pkg.sv
// Shared types, widths and constants of the go-to-goal proportional controller.
// Used by the CORDIC unit, the square-root unit and the top level.
// Depends on nothing.
package gtg_pkg;

    // Field widths of the stream items and configuration registers.
    localparam int POS_W       = 18;
    localparam int HEAD_W      = 15;
    localparam int GAIN_W      = 12;
    localparam int TOL_W       = 12;
    localparam int TURN_W      = 18;
    localparam int SPEED_W     = 19;
    localparam int DIST_W      = 19;
    localparam int STATUS_W    = 3;
    localparam int ELAPSED_W   = 16;
    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 18;

    // Internal datapath widths.
    localparam int DIFF_W  = POS_W + 1;          // target minus pose
    localparam int CORD_W  = 30;                 // CORDIC x and y, Q.20 with headroom
    localparam int Z_W     = 21;                 // CORDIC angle, Q16 radians
    localparam int BEAR_W  = Z_W - 4;            // bearing, Q12 radians
    localparam int ERR_W   = 18;                 // heading error, Q12 radians
    localparam int SQ_W    = 2 * DIST_W;         // dx*dx + dy*dy
    localparam int MUL_W   = 20;                 // shared multiplier operand width
    localparam int PROD_W  = 2 * MUL_W;

    // Arctangent table, Q16 radians; entries beyond 2^-16 are zero.
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W   = 5;
    localparam int ATAN_W       = 16;
    localparam logic [ATAN_W-1:0] ATAN_Q16 [ATAN_ENTRIES] = '{
        16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
        16'd256,   16'd128,   16'd64,    16'd32,   16'd16,   16'd8,    16'd4,    16'd2,
        16'd1,     16'd0,     16'd0,     16'd0,    16'd0,    16'd0,    16'd0,    16'd0
    };
    localparam logic signed [Z_W-1:0] PI_Q16 = 21'sd205887;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_TURNING  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DRIVING  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_REACHED  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_CANCELED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_IDLE     = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LINEAR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_ANGULAR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 3'd4;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SQX   = 8'b0000_0010,
        S_SQY   = 8'b0000_0100,
        S_START = 8'b0000_1000,
        S_RUN   = 8'b0001_0000,
        S_ERR   = 8'b0010_0000,
        S_MUL   = 8'b0100_0000,
        S_WRITE = 8'b1000_0000
    } t_state;

endpackage

### design/gtg_cordic.sv
// Iterative vectoring CORDIC: one shift-add rotation per cycle, bearing in Q12 radians.
// Depends on gtg_pkg for widths, the arctangent table and pi.
module gtg_cordic import gtg_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DIFF_W-1:0] i_dx,
    input  logic signed [DIFF_W-1:0] i_dy,
    output logic                     o_busy,
    output logic signed [BEAR_W-1:0] o_bearing
);

    localparam int STEPS_USED = (STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS;
    localparam int CW = $clog2(STEPS_USED + 1);
    localparam logic [CW-1:0] LAST = CW'(STEPS_USED - 1);

    logic                     r_busy;
    logic [CW-1:0]            r_cnt;
    logic signed [CORD_W-1:0] r_x;
    logic signed [CORD_W-1:0] r_y;
    logic signed [Z_W-1:0]    r_z;

    logic signed [CORD_W-1:0] x_init;
    logic signed [CORD_W-1:0] y_init;
    logic signed [CORD_W-1:0] x_sh;
    logic signed [CORD_W-1:0] y_sh;
    logic signed [Z_W-1:0]    atan_ext;
    logic signed [Z_W-1:0]    z_round;

    // Scale the differences by 256 to gain fraction bits for the iterations.
    assign x_init = signed'({{(CORD_W-DIFF_W-8){i_dx[DIFF_W-1]}}, i_dx, 8'b0});
    assign y_init = signed'({{(CORD_W-DIFF_W-8){i_dy[DIFF_W-1]}}, i_dy, 8'b0});

    // Shared shifter and table lookup for the current iteration.
    assign x_sh     = r_x >>> r_cnt;
    assign y_sh     = r_y >>> r_cnt;
    assign atan_ext = signed'({{(Z_W-ATAN_W){1'b0}}, ATAN_Q16[ATAN_IDX_W'(r_cnt)]});

    // Round half up from Q16 to Q12.
    assign z_round   = (r_z + 21'sd8) >>> 4;
    assign o_bearing = z_round[BEAR_W-1:0];
    assign o_busy    = r_busy;

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= (i_dx != '0) || (i_dy != '0);
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Rotation datapath; a vector in the left half plane is first turned by pi.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            if (i_dx < 0) begin
                r_x <= -x_init;
                r_y <= -y_init;
                r_z <= (i_dy >= 0) ? PI_Q16 : -PI_Q16;
            end else begin
                r_x <= x_init;
                r_y <= y_init;
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (r_y > 0) begin
                r_x <= r_x + y_sh;
                r_y <= r_y - x_sh;
                r_z <= r_z + atan_ext;
            end else begin
                r_x <= r_x - y_sh;
                r_y <= r_y + x_sh;
                r_z <= r_z - atan_ext;
            end
        end
    end

endmodule

### design/gtg_isqrt.sv
// Iterative integer square root, one result bit per cycle (restoring digit recurrence).
// Depends on gtg_pkg for the radicand and root widths.
module gtg_isqrt import gtg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_W-1:0]   i_radicand,
    output logic              o_busy,
    output logic [DIST_W-1:0] o_root
);

    localparam int CW  = $clog2(DIST_W);
    localparam int REM_W = DIST_W + 2;
    localparam logic [CW-1:0] LAST = CW'(DIST_W - 1);

    logic                r_busy;
    logic [CW-1:0]       r_cnt;
    logic [SQ_W-1:0]     r_rad;
    logic [REM_W-1:0]    r_rem;
    logic [DIST_W-1:0]   r_root;

    logic [REM_W+1:0]    rem_sh;
    logic [REM_W+1:0]    trial;

    // Bring down the next two radicand bits and form the trial subtrahend.
    assign rem_sh = {r_rem, r_rad[SQ_W-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};

    assign o_busy = r_busy;
    assign o_root = r_root;

    // Step control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    // One root bit per step.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[SQ_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= REM_W'(rem_sh - trial);
                r_root <= {r_root[DIST_W-2:0], 1'b1};
            end else begin
                r_rem  <= REM_W'(rem_sh);
                r_root <= {r_root[DIST_W-2:0], 1'b0};
            end
        end
    end

endmodule

### design/go_to_goal_p_controller.sv
// Go-to-goal proportional controller. An idle or canceled tick goes straight to the write state;
// a turning or driving tick passes the square states, start, run (until both units are done),
// error and multiply, and a reached tick skips multiply. The 19-step square-root unit and the
// CORDIC iteration count (capped at 24) set the long path. One item is processed at a time;
// a new item is taken once the sequencer is back in idle; the write state waits for out_free.
// Reset (synchronous, active low) restores the register defaults, clears the count, sets finished.
module go_to_goal_p_controller import gtg_pkg::*; #(
    parameter int CORDIC_STEPS = 16,
    parameter int COUNT_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Pose items.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // pose_x[17:0], pose_y[35:18],
                                                  // pose_heading[50:36], zero[55:51]
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // new_goal[0], cancel_request[1]
    // Command items.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // turn_rate[17:0], forward_speed[36:18],
                                                  // distance[55:37], elapsed[71:56]
    output logic [STATUS_W-1:0]    m_axis_tuser,  // status[2:0]
    // Register writes.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    t_state                   r_state;
    t_state                   n_state;

    logic signed [POS_W-1:0]  r_target_x;
    logic signed [POS_W-1:0]  r_target_y;
    logic [GAIN_W-1:0]        r_gain_lin;
    logic [GAIN_W-1:0]        r_gain_ang;
    logic [TOL_W-1:0]         r_tol;
    logic [COUNT_BITS-1:0]    r_tick;
    logic                     r_finished;

    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic signed [HEAD_W-1:0] r_heading;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [ERR_W-1:0]  r_err;
    logic [DIST_W-1:0]        r_dist;
    logic [STATUS_W-1:0]      r_status;
    logic [ELAPSED_W-1:0]     r_elapsed;

    logic                     r_out_valid;
    logic signed [TURN_W-1:0] r_out_turn;
    logic [SPEED_W-1:0]       r_out_fwd;
    logic [DIST_W-1:0]        r_out_dist;
    logic [STATUS_W-1:0]      r_out_status;
    logic [ELAPSED_W-1:0]     r_out_elapsed;

    logic                     in_accept;
    logic                     out_free;
    logic signed [POS_W-1:0]  pose_x;
    logic signed [POS_W-1:0]  pose_y;
    logic signed [HEAD_W-1:0] pose_heading;
    logic                     new_goal;
    logic                     cancel_request;
    logic                     fin_eff;
    logic [COUNT_BITS-1:0]    cnt_eff;
    logic [ELAPSED_W-1:0]     elapsed_eff;

    logic                     cordic_busy;
    logic signed [BEAR_W-1:0] bearing;
    logic                     sqrt_busy;
    logic [DIST_W-1:0]        root;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ERR_W-1:0]  err;
    logic [ERR_W-1:0]         aerr;
    logic signed [PROD_W-1:0] rnd;
    logic signed [TURN_W-1:0] turn_sat;
    logic [SPEED_W-1:0]       fwd_sat;

    // Unpack the input item.
    assign pose_x         = s_axis_tdata[POS_W-1:0];
    assign pose_y         = s_axis_tdata[2*POS_W-1:POS_W];
    assign pose_heading   = s_axis_tdata[2*POS_W+HEAD_W-1:2*POS_W];
    assign new_goal       = s_axis_tuser[0];
    assign cancel_request = s_axis_tuser[1];

    // Register writes are taken only between items.
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = (r_state == S_IDLE);

    // A new goal clears the count and the finished flag before the tick is handled.
    assign fin_eff = new_goal ? 1'b0 : r_finished;
    assign cnt_eff = new_goal ? '0 : r_tick;
    assign elapsed_eff = (33'(cnt_eff) > 33'd65535) ? '1 : ELAPSED_W'(cnt_eff);

    // Shared multiplier: squares of the differences, then the gain product.
    always_comb begin
        unique case (r_state)
            S_SQX: begin
                mul_a = MUL_W'(r_dx);
                mul_b = MUL_W'(r_dx);
            end
            S_SQY: begin
                mul_a = MUL_W'(r_dy);
                mul_b = MUL_W'(r_dy);
            end
            default: begin
                if (r_status == STAT_TURNING) begin
                    mul_a = signed'({{(MUL_W-GAIN_W){1'b0}}, r_gain_ang});
                    mul_b = MUL_W'(r_err);
                end else begin
                    mul_a = signed'({{(MUL_W-GAIN_W){1'b0}}, r_gain_lin});
                    mul_b = signed'({{(MUL_W-DIST_W){1'b0}}, r_dist});
                end
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    // Heading error against the bearing, with its magnitude.
    assign err  = ERR_W'(bearing) - ERR_W'(r_heading);
    assign aerr = (err < 0) ? ERR_W'(-err) : ERR_W'(err);

    // Round half up, then saturate to the command ranges.
    assign rnd = (r_acc + 40'sd128) >>> 8;
    always_comb begin
        if (rnd > 40'sd131071) begin
            turn_sat = 18'sd131071;
        end else if (rnd < -40'sd131072) begin
            turn_sat = -18'sd131072;
        end else begin
            turn_sat = TURN_W'(rnd);
        end
        if (rnd > 40'sd524287) begin
            fwd_sat = '1;
        end else if (rnd < 0) begin
            fwd_sat = '0;
        end else begin
            fwd_sat = SPEED_W'(rnd);
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = (fin_eff || cancel_request) ? S_WRITE : S_SQX;
                end
            end
            S_SQX:   n_state = S_SQY;
            S_SQY:   n_state = S_START;
            S_START: n_state = S_RUN;
            S_RUN: begin
                if (!cordic_busy && !sqrt_busy) begin
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                n_state = ((aerr > ERR_W'(r_tol)) || (root > DIST_W'(r_tol))) ? S_MUL : S_WRITE;
            end
            S_MUL: n_state = S_WRITE;
            S_WRITE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x <= '0;
            r_target_y <= '0;
            r_gain_lin <= 12'd128;
            r_gain_ang <= 12'd512;
            r_tol      <= 12'd41;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TARGET_X:     r_target_x <= i_cfg_data;
                CFG_TARGET_Y:     r_target_y <= i_cfg_data;
                CFG_GAIN_LINEAR:  r_gain_lin <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_ANGULAR: r_gain_ang <= i_cfg_data[GAIN_W-1:0];
                CFG_TOLERANCE:    r_tol      <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Goal state: tick count and finished flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick     <= '0;
            r_finished <= 1'b1;
        end else if (in_accept) begin
            r_tick     <= cnt_eff;
            r_finished <= fin_eff || cancel_request;
        end else if ((r_state == S_WRITE) && out_free) begin
            if (((r_status == STAT_TURNING) || (r_status == STAT_DRIVING))
                    && (r_tick != COUNT_MAX)) begin
                r_tick <= r_tick + 1'b1;
            end
            if (r_status == STAT_REACHED) begin
                r_finished <= 1'b1;
            end
        end
    end

    // Working registers of the item in flight.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_dx      <= DIFF_W'(r_target_x) - DIFF_W'(pose_x);
            r_dy      <= DIFF_W'(r_target_y) - DIFF_W'(pose_y);
            r_heading <= pose_heading;
            r_elapsed <= elapsed_eff;
            r_dist    <= '0;
            if (fin_eff) begin
                r_status <= STAT_IDLE;
            end else begin
                r_status <= STAT_CANCELED;
            end
        end
        unique case (r_state)
            S_SQX: r_acc <= prod;
            S_SQY: r_acc <= r_acc + prod;
            S_ERR: begin
                r_dist <= root;
                r_err  <= err;
                priority if (aerr > ERR_W'(r_tol)) begin
                    r_status <= STAT_TURNING;
                end else if (root > DIST_W'(r_tol)) begin
                    r_status <= STAT_DRIVING;
                end else begin
                    r_status <= STAT_REACHED;
                end
            end
            S_MUL: r_acc <= prod;
            default: ;
        endcase
    end

    // Output register; a result waits here until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_WRITE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_WRITE) && out_free) begin
            r_out_turn    <= (r_status == STAT_TURNING) ? turn_sat : '0;
            r_out_fwd     <= (r_status == STAT_DRIVING) ? fwd_sat : '0;
            r_out_dist    <= r_dist;
            r_out_status  <= r_status;
            r_out_elapsed <= r_elapsed;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_elapsed, r_out_dist, r_out_fwd, r_out_turn};
    assign m_axis_tuser  = r_out_status;

    // Bearing and distance units, started together.
    gtg_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == S_START),
        .i_dx      (r_dx),
        .i_dy      (r_dy),
        .o_busy    (cordic_busy),
        .o_bearing (bearing)
    );

    gtg_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_START),
        .i_radicand (r_acc[SQ_W-1:0]),
        .o_busy     (sqrt_busy),
        .o_root     (root)
    );

endmodule
